// ----- rtl/rokt_pkg.sv -----
// ----------------------------------------------------------------------------
// rokt_pkg
// shared sizes, codes and command/status types of the recency ordered key table
// ----------------------------------------------------------------------------
package rokt_pkg;

    // table geometry
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // configuration register widths and resets
    localparam int CAP_W   = 5;
    localparam int VB_W    = 4;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VB_W-1:0]  VB_RESET  = 4'd8;
    localparam logic [VB_W-1:0]  VB_MAX    = 4'd8;

    // register indexes (paddr[2])
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_VALUE_BYTES = 1'b1;

    // opcodes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_CORRUPT  = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
    } entry_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [VB_W-1:0]  value_bytes;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       shift_start;
        logic       walk;
        logic       shift_mode;
        logic       clear;
        logic       dec;
        logic       append;
        logic       finish;
        logic [1:0] res_status;
        logic       res_evicted;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       over;
        logic       full;
        logic       match;
        logic       walk_end;
        logic       res_free;
    } dp_status_t;

endpackage

// ----- rtl/rokt_regs.sv -----
// ----------------------------------------------------------------------------
// rokt_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module rokt_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rokt_pkg::PADDR_W-1:0] paddr,
    input  logic [rokt_pkg::PDATA_W-1:0] pwdata,
    output logic [rokt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output rokt_pkg::cfg_t               cfg
);
    import rokt_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic [VB_W-1:0]  value_bytes_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            value_bytes_reg <= VB_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_CAPACITY:    capacity_reg    <= pwdata[CAP_W-1:0];
                REG_VALUE_BYTES: value_bytes_reg <= pwdata[VB_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CAPACITY:    prdata = PDATA_W'(capacity_reg);
            REG_VALUE_BYTES: prdata = PDATA_W'(value_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.capacity    = capacity_reg;
    assign cfg.value_bytes = value_bytes_reg;

endmodule

// ----- rtl/rokt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rokt_ctrl
// sequencer: dispatch, key scan, gap closing, append and result hand-off
// ----------------------------------------------------------------------------
module rokt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rokt_pkg::dp_status_t dp_status,
    output rokt_pkg::ctrl_cmd_t  cmd
);
    import rokt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_WRITE    = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       evict_reg;
    logic       evict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            evict_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            evict_reg  <= evict_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        evict_next      = evict_reg;
        cmd             = '0;
        cmd.res_status  = status_reg;
        cmd.res_evicted = evict_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next = ST_OK;
                evict_next  = 1'b0;
                if (dp_status.op == OP_NOP)
                begin
                    state_next = S_FINISH;
                end
                else if (dp_status.op inside {OP_LOOKUP, OP_DELETE} && dp_status.empty)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_FINISH;
                end
                else if (dp_status.op == OP_ADD && dp_status.over)
                begin
                    cmd.clear   = 1'b1;
                    status_next = ST_CORRUPT;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.walk = 1'b1;
                if (dp_status.match)
                begin
                    if (dp_status.op == OP_LOOKUP)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end
                end
                else if (dp_status.walk_end)
                begin
                    if (dp_status.op != OP_ADD)
                    begin
                        status_next = ST_NOTFOUND;
                        state_next  = S_FINISH;
                    end
                    else if (dp_status.full)
                    begin
                        // drop the oldest entry first
                        cmd.shift_start = 1'b1;
                        evict_next      = 1'b1;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.walk       = 1'b1;
                cmd.shift_mode = 1'b1;
                if (dp_status.walk_end)
                begin
                    cmd.dec    = 1'b1;
                    state_next = (dp_status.op == OP_DELETE) ? S_FINISH : S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.append = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (dp_status.res_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rokt_dpath.sv -----
// ----------------------------------------------------------------------------
// rokt_dpath
// entry memory, count, item and result registers, walk counter
// ----------------------------------------------------------------------------
module rokt_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rokt_pkg::cfg_t       cfg,
    input  logic [1:0]           opcode,
    input  logic [63:0]          key,
    input  logic [63:0]          value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [63:0]          value_out,
    output logic [4:0]           entry_count,
    output logic                 evicted,
    input  rokt_pkg::ctrl_cmd_t  cmd,
    output rokt_pkg::dp_status_t dp_status
);
    import rokt_pkg::*;

    entry_t entry_mem [ENTRIES];

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      walk_idx_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_tag_reg;
    entry_t                rdata_reg;
    logic                  hit_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [63:0]           value_out_reg;
    logic [4:0]            entry_count_reg;
    logic                  evicted_reg;

    logic [VB_W-1:0]       nbytes;
    logic [63:0]           mask64;
    logic [VALUE_BITS-1:0] vmask;
    logic [CMP_W-1:0]      cap_w;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      count_w;
    logic                  match;
    logic                  issue;
    logic [CNT_W-1:0]      shift_from;
    logic                  mem_we;
    logic [IDX_W-1:0]      waddr;
    entry_t                wdata;
    logic [VALUE_BITS-1:0] new_val;

    // byte mask from value_bytes, limited to eight bytes
    always_comb
    begin
        nbytes = (cfg.value_bytes > VB_MAX) ? VB_MAX : cfg.value_bytes;
        for (int b = 0; b < 8; b++)
        begin
            mask64[b*8 +: 8] = (VB_W'(b) < nbytes) ? 8'hff : 8'h00;
        end
        vmask = mask64[VALUE_BITS-1:0];
    end

    // effective capacity
    always_comb
    begin
        cap_w = CMP_W'(cfg.capacity);
        if (cfg.capacity == '0)
            cap_eff = CMP_W'(1);
        else if (cap_w > CMP_W'(ENTRIES))
            cap_eff = CMP_W'(ENTRIES);
        else
            cap_eff = cap_w;
    end

    assign count_w    = CMP_W'(count_reg);
    assign match      = rd_valid_reg && (rdata_reg.key == key_reg);
    assign issue      = cmd.walk && !cmd.shift_start && (walk_idx_reg < count_reg);
    assign shift_from = match ? (CNT_W'(rd_tag_reg) + CNT_W'(1)) : CNT_W'(1);

    assign new_val = hit_reg ? ((hit_val_reg & ~vmask) | (val_reg & vmask))
                             : (val_reg & vmask);

    assign mem_we = cmd.append || (cmd.walk && cmd.shift_mode && rd_valid_reg);
    assign waddr  = cmd.append ? count_reg[IDX_W-1:0] : (rd_tag_reg - IDX_W'(1));
    always_comb
    begin
        if (cmd.append)
        begin
            wdata.key = key_reg;
            wdata.val = new_val;
        end
        else
        begin
            wdata = rdata_reg;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[waddr] <= wdata;
        if (issue)
            rdata_reg <= entry_mem[walk_idx_reg[IDX_W-1:0]];
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key[KEY_BITS-1:0];
            val_reg <= value[VALUE_BITS-1:0];
        end
        if (cmd.walk && !cmd.shift_mode && match && !hit_reg)
            hit_val_reg <= rdata_reg.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            walk_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_tag_reg   <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.dec)
                count_reg <= count_reg - CNT_W'(1);
            else if (cmd.append)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.scan_start)
            begin
                walk_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.shift_start)
            begin
                walk_idx_reg <= shift_from;
                rd_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                walk_idx_reg <= walk_idx_reg + CNT_W'(1);
                rd_valid_reg <= 1'b1;
                rd_tag_reg   <= walk_idx_reg[IDX_W-1:0];
            end
            else
            begin
                rd_valid_reg <= 1'b0;
            end

            if (cmd.load)
                hit_reg <= 1'b0;
            else if (cmd.walk && !cmd.shift_mode && match)
                hit_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg      <= cmd.res_status;
            evicted_reg     <= cmd.res_evicted;
            entry_count_reg <= count_w[4:0];
            value_out_reg   <= (op_reg == OP_LOOKUP && hit_reg) ? 64'(hit_val_reg & vmask)
                                                                 : 64'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;
    assign evicted     = evicted_reg;

    assign dp_status.op       = op_reg;
    assign dp_status.empty    = (count_reg == '0);
    assign dp_status.over     = (count_w > cap_eff);
    assign dp_status.full     = (count_w >= cap_eff);
    assign dp_status.match    = match;
    assign dp_status.walk_end = !rd_valid_reg && (walk_idx_reg >= count_reg);
    assign dp_status.res_free = !out_valid_reg || !out_stall;

endmodule

// ----- rtl/recency_ordered_key_table.sv -----
// ----------------------------------------------------------------------------
// recency_ordered_key_table
// key/value table kept oldest first, with add/refresh, lookup and delete
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------------
//  config    in         psel/penable/pwrite, pready  paddr, pwdata, prdata
//  item      in         in_valid / in_stall          opcode, key, value
//  result    out        out_valid / out_stall        status, value_out, entry_count,
//                                                    evicted
//
//  one transaction is in work at a time: accept, dispatch, a key scan of up to
//  count entries, a gap close, an append and a hand-off before the next accept;
//  the single-port read and single-port write of the entry memory set the scan
//  and shift rate
//  reset clears the count and the controller; memory contents are left as found
//  and only entries below the count are ever read, so no clearing pass is needed
//  a finished result sits in the output register; the next item is taken while
//  it waits, and only the hand-off of the following result waits on out_stall
//
module recency_ordered_key_table (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rokt_pkg::PADDR_W-1:0] paddr,
    input  logic [rokt_pkg::PDATA_W-1:0] pwdata,
    output logic [rokt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // item channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [63:0]                  key,
    input  logic [63:0]                  value,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [63:0]                  value_out,
    output logic [4:0]                   entry_count,
    output logic                         evicted
);
    import rokt_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // capacity and value byte registers
    rokt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: decides scan, gap close and append from datapath status
    rokt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // entry memory, count and result register
    rokt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count),
        .evicted     (evicted),
        .cmd         (cmd),
        .dp_status   (dp_status)
    );

endmodule

// ----- rtl/rokt_checker.sv -----
// ----------------------------------------------------------------------------
// rokt_checker
// port-level checks on the recency ordered key table
// ----------------------------------------------------------------------------
module rokt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [1:0]                   status,
    input logic [63:0]                  value_out,
    input logic [4:0]                   entry_count,
    input logic                         evicted
);
    import rokt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
            && $stable(entry_count) && $stable(evicted))
        else $error("stalled result changed");

    // one transaction at a time: busy after each accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous still in work");

    // only a lookup hit carries a value
    a_value_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value_out == 64'd0)
        else $error("value returned with failing status");

    // eviction only with an ok status and a non-empty table
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> status == ST_OK && entry_count != 5'd0)
        else $error("eviction flagged on failing or empty result");

    // empty and corrupt results leave nothing in the table
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_CORRUPT) |-> entry_count == 5'd0)
        else $error("empty or cleared table reports entries");

endmodule

bind recency_ordered_key_table rokt_checker u_rokt_checker (.*);
